// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms clocked on clk, qualified by rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_HOLDS(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// condition that must hold on the cycle after reset is sampled
`define ASSERT_AFTER_RESET(label, cons) \
  label: assert property (@(posedge clk) !rst_n |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/bwa_pkg.sv
// ----------------------------------------------------------------------------
// bwa_pkg
// Types, constants and the quarter-wave cosine ROM for the Blackman window.
// ----------------------------------------------------------------------------
package bwa_pkg;

  localparam int MAX_LENGTH = 4096;
  localparam int COS_DEPTH  = 1024;

  localparam int SAMPLE_W = 16;
  localparam int LEN_W    = 13;
  localparam int PHASE_W  = 24;
  localparam int ALPHA_W  = 16;
  localparam int CFG_IW   = 2;
  localparam int CFG_DW   = 24;

  localparam int QUAD_W   = PHASE_W - 2;
  localparam int COS_AW   = $clog2(COS_DEPTH + 1);
  localparam int COS_MAG_W = 16;
  localparam int SCALE_W  = QUAD_W + COS_AW;

  localparam int W_W      = 34;
  localparam int PROD_W   = W_W + SAMPLE_W;

  localparam int QDEPTH   = 4;
  localparam int QAW      = $clog2(QDEPTH);

  localparam logic [CFG_IW-1:0] CFG_WINDOW_LENGTH = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_PHASE_STEP    = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_ALPHA         = 2'd2;

  localparam logic [LEN_W-1:0]   WINDOW_LENGTH_RESET = 13'd4096;
  localparam logic [PHASE_W-1:0] PHASE_STEP_RESET    = 24'd4096;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET         = 16'd10486;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [PHASE_W-1:0]         phase;
    logic                       last;
  } bwa_item_t;

  typedef struct packed {
    logic [COS_AW-1:0] addr;
    logic              neg;
  } cos_sel_t;

  typedef logic [COS_MAG_W-1:0] cos_rom_t [0:COS_DEPTH];

  function automatic cos_rom_t cos_rom_build();
    cos_rom_t           rom;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    for (int k = 0; k < COS_DEPTH; k++) begin
      x    = (HALF_PI_Q30 * 64'(k)) / 64'(COS_DEPTH);
      x2   = (x * x) >> 30;
      term = 64'd1 << 30;
      sum  = signed'(term);
      for (int n = 1; n <= 7; n++) begin
        term = ((term * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
        if ((n % 2) == 1) begin
          sum = sum - signed'(term);
        end else begin
          sum = sum + signed'(term);
        end
      end
      if (sum < 0) begin
        sum = 64'sd0;
      end
      sum = (sum + 64'sd16384) >>> 15;
      if (sum > 64'sd32768) begin
        sum = 64'sd32768;
      end
      rom[k] = COS_MAG_W'(sum);
    end
    rom[COS_DEPTH] = '0;
    return rom;
  endfunction

  localparam cos_rom_t COS_ROM = cos_rom_build();

  function automatic cos_sel_t cos_select(input logic [PHASE_W-1:0] phase);
    cos_sel_t            sel;
    logic [SCALE_W-1:0]  scaled;
    logic [COS_AW-1:0]   j;
    scaled = SCALE_W'(phase[QUAD_W-1:0]) * SCALE_W'(COS_DEPTH);
    j      = COS_AW'(scaled >> QUAD_W);
    sel.addr = phase[PHASE_W-1-1] ? (COS_AW'(COS_DEPTH) - j) : j;
    sel.neg  = phase[PHASE_W-1] ^ phase[PHASE_W-2];
    return sel;
  endfunction

endpackage

// File: rtl/blackman_window_apply.sv
// ----------------------------------------------------------------------------
// blackman_window_apply
// Multiplies a Q1.15 sample stream by a generalized Blackman window.
// ----------------------------------------------------------------------------
// Channels: in_* carries one signed sample per item, out_* returns the
// windowed sample and a window_end flag set on the last sample of a window,
// cfg_* writes window_length (0), phase_step (1) and alpha (2). The config
// port is always ready; write it only while no items are in flight.
// Throughput: one item per cycle while out_ready holds. Each item is
// registered in the queue, then passes the back end's pipeline (cosine ROM
// read, weight multiply, sample multiply, round and saturate) to out_valid.
// A four-entry queue separates the front from the back; the front keeps
// taking items until it fills.
// Reset (synchronous, active low): index and phase go to zero, registers to
// their defaults, queue and pipeline empty. The cosine ROM is constant and
// needs no fill.
// Receiver stall: out_* holds; the back pipeline freezes, the queue fills and
// in_ready drops once it is full.
// ----------------------------------------------------------------------------
module blackman_window_apply import bwa_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] in_sample_in,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] out_sample_out,
  output logic                       out_window_end,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IW-1:0]          cfg_index,
  input  logic [CFG_DW-1:0]          cfg_data
);

  logic               q_full;
  logic               push;
  bwa_item_t          push_item;
  logic               pop;
  logic               q_valid;
  bwa_item_t          q_item;
  logic [ALPHA_W-1:0] alpha;

  bwa_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_sample_in (in_sample_in),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .q_full       (q_full),
    .push         (push),
    .push_item    (push_item),
    .alpha        (alpha)
  );

  bwa_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (pop),
    .head_valid (q_valid),
    .head_item  (q_item)
  );

  bwa_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .pop            (pop),
    .alpha          (alpha),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sample_out (out_sample_out),
    .out_window_end (out_window_end)
  );

endmodule

// File: rtl/bwa_front.sv
// ----------------------------------------------------------------------------
// bwa_front
// Holds configuration, tracks window index and phase, tags each item.
// ----------------------------------------------------------------------------
module bwa_front import bwa_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] in_sample_in,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IW-1:0]          cfg_index,
  input  logic [CFG_DW-1:0]          cfg_data,
  input  logic                       q_full,
  output logic                       push,
  output bwa_item_t                  push_item,
  output logic [ALPHA_W-1:0]         alpha
);

  logic [LEN_W-1:0]   window_length_r;
  logic [PHASE_W-1:0] phase_step_r;
  logic [ALPHA_W-1:0] alpha_r;
  logic [LEN_W-1:0]   sample_index_r;
  logic [PHASE_W-1:0] phase_acc_r;

  logic [LEN_W-1:0]   len_eff;
  logic [PHASE_W-1:0] phase_nxt;
  logic               last;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign push      = in_valid && in_ready;
  assign alpha     = alpha_r;

  always_comb begin
    if (window_length_r < LEN_W'(2)) begin
      len_eff = LEN_W'(2);
    end else if (32'(window_length_r) > MAX_LENGTH) begin
      len_eff = LEN_W'(MAX_LENGTH);
    end else begin
      len_eff = window_length_r;
    end
    phase_nxt        = phase_acc_r + phase_step_r;
    last             = sample_index_r >= (len_eff - LEN_W'(1));
    push_item.sample = in_sample_in;
    push_item.phase  = phase_nxt;
    push_item.last   = last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_length_r <= WINDOW_LENGTH_RESET;
      phase_step_r    <= PHASE_STEP_RESET;
      alpha_r         <= ALPHA_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_WINDOW_LENGTH: window_length_r <= cfg_data[LEN_W-1:0];
        CFG_PHASE_STEP:    phase_step_r    <= cfg_data[PHASE_W-1:0];
        CFG_ALPHA:         alpha_r         <= cfg_data[ALPHA_W-1:0];
        default: ;
      endcase
    end
  end

  // advance index and phase; wrap both at window end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_index_r <= '0;
      phase_acc_r    <= '0;
    end else if (push) begin
      if (last) begin
        sample_index_r <= '0;
        phase_acc_r    <= '0;
      end else begin
        sample_index_r <= sample_index_r + LEN_W'(1);
        phase_acc_r    <= phase_nxt;
      end
    end
  end

endmodule

// File: rtl/bwa_fifo.sv
// ----------------------------------------------------------------------------
// bwa_fifo
// Short item queue between the front and back.
// ----------------------------------------------------------------------------
module bwa_fifo import bwa_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  bwa_item_t push_item,
  output logic      full,
  input  logic      pop,
  output logic      head_valid,
  output bwa_item_t head_item
);

  bwa_item_t        slot_r [0:QDEPTH-1];
  logic [QAW-1:0]   wr_ptr_r;
  logic [QAW-1:0]   rd_ptr_r;
  logic [QAW:0]     count_r;

  assign full       = count_r == (QAW+1)'(QDEPTH);
  assign head_valid = count_r != '0;
  assign head_item  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QAW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QAW'(1);
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + (QAW+1)'(1);
        2'b01:   count_r <= count_r - (QAW+1)'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// File: rtl/bwa_back.sv
// ----------------------------------------------------------------------------
// bwa_back
// Cosine lookup, weight build, sample multiply, round and saturate.
// ----------------------------------------------------------------------------
module bwa_back import bwa_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  input  bwa_item_t                   q_item,
  output logic                        pop,
  input  logic [ALPHA_W-1:0]          alpha,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [SAMPLE_W-1:0]  out_sample_out,
  output logic                        out_window_end
);

  localparam int RND_W = PROD_W + 1;
  localparam int Y_W   = RND_W - 32;

  logic                       adv;
  cos_sel_t                   sel1;
  cos_sel_t                   sel2;

  logic                       s1_valid_r;
  logic [COS_MAG_W-1:0]       c1_mag_r;
  logic [COS_MAG_W-1:0]       c2_mag_r;
  logic                       c1_neg_r;
  logic                       c2_neg_r;
  logic signed [SAMPLE_W-1:0] s1_sample_r;
  logic                       s1_last_r;

  logic signed [COS_MAG_W:0]  c1;
  logic signed [COS_MAG_W:0]  c2;
  logic [ALPHA_W:0]           one_minus;
  logic signed [ALPHA_W:0]    alpha_s;
  logic signed [W_W-1:0]      term_a;
  logic signed [W_W-1:0]      term_b;
  logic signed [W_W-1:0]      term_c;
  logic signed [W_W-1:0]      w_nxt;

  logic                       s2_valid_r;
  logic signed [W_W-1:0]      w_r;
  logic signed [SAMPLE_W-1:0] s2_sample_r;
  logic                       s2_last_r;

  logic                       s3_valid_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic                       s3_last_r;

  logic signed [RND_W-1:0]    rnd;
  logic signed [Y_W-1:0]      y;
  logic signed [SAMPLE_W-1:0] y_sat;

  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;
  logic                       out_last_r;

  assign adv            = !out_valid_r || out_ready;
  assign pop            = adv && q_valid;
  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_window_end = out_last_r;

  assign sel1 = cos_select(q_item.phase);
  assign sel2 = cos_select({q_item.phase[PHASE_W-2:0], 1'b0});

  always_comb begin
    c1        = c1_neg_r ? -signed'({1'b0, c1_mag_r}) : signed'({1'b0, c1_mag_r});
    c2        = c2_neg_r ? -signed'({1'b0, c2_mag_r}) : signed'({1'b0, c2_mag_r});
    one_minus = (ALPHA_W+1)'(1 << ALPHA_W) - {1'b0, alpha};
    alpha_s   = signed'({1'b0, alpha});
    term_a    = signed'({2'b00, one_minus, 15'd0});
    term_b    = signed'({c1[COS_MAG_W], c1, 16'd0});
    term_c    = W_W'(alpha_s) * W_W'(c2);
    w_nxt     = term_a - term_b + term_c;
  end

  always_comb begin
    rnd = RND_W'(prod_r) + (RND_W'(1) <<< 31);
    y   = Y_W'(rnd >>> 32);
    if (y > Y_W'(32767)) begin
      y_sat = 16'sh7FFF;
    end else if (y < -Y_W'(32768)) begin
      y_sat = -16'sh8000;
    end else begin
      y_sat = SAMPLE_W'(y);
    end
  end

  // payload stages; advance together, hold on output stall
  always_ff @(posedge clk) begin
    if (adv) begin
      c1_mag_r     <= COS_ROM[sel1.addr];
      c2_mag_r     <= COS_ROM[sel2.addr];
      c1_neg_r     <= sel1.neg;
      c2_neg_r     <= sel2.neg;
      s1_sample_r  <= q_item.sample;
      s1_last_r    <= q_item.last;
      w_r          <= w_nxt;
      s2_sample_r  <= s1_sample_r;
      s2_last_r    <= s1_last_r;
      prod_r       <= PROD_W'(s2_sample_r) * PROD_W'(w_r);
      s3_last_r    <= s2_last_r;
      out_sample_r <= y_sat;
      out_last_r   <= s3_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= q_valid;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      out_valid_r <= s3_valid_r;
    end
  end

endmodule

// File: rtl/bwa_checker.sv
// ----------------------------------------------------------------------------
// bwa_checker
// Port-level checks for blackman_window_apply, attached by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bwa_checker import bwa_pkg::*; (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic signed [SAMPLE_W-1:0] out_sample_out,
  input logic                       out_window_end,
  input logic                       cfg_valid,
  input logic                       cfg_ready
);

  logic [SAMPLE_W:0] out_payload;

  assign out_payload = {out_sample_out, out_window_end};

  `ASSERT_NEXT(out_hold_on_stall, out_valid && !out_ready, out_valid && $stable(out_payload))
  `ASSERT_AFTER_RESET(out_empty_after_reset, !out_valid)
  `ASSERT_AFTER_RESET(in_ready_after_reset, in_ready)
  `ASSERT_HOLDS(cfg_never_blocks, cfg_valid, cfg_ready)

endmodule

bind blackman_window_apply bwa_checker u_bwa_checker (.*);

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for blackman_window_apply. A cycle-free predictor
// tracks window index, phase and registers, computes the windowed sample and
// end flag for every accepted item, and compares each returned item in order.
// Directed tests cover sample extremes, quadrants, short and clamped lengths,
// zero step, alpha extremes, mid-window length change and the spare register
// index; random windows also sweep settings under bursty input and stalled
// output.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bwa_pkg::*;

  localparam logic [CFG_IW-1:0] CFG_SPARE = 2'd3;
  localparam int RANDOM_ITEMS = 1100;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value;
    logic                       last;
  } windowed_t;

  typedef enum int {RX_FREE, RX_CHOPPY, RX_BLOCKY} rx_style_t;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] in_sample_in;
  logic                       out_valid;
  logic                       out_ready;
  logic signed [SAMPLE_W-1:0] out_sample_out;
  logic                       out_window_end;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [CFG_IW-1:0]          cfg_index;
  logic [CFG_DW-1:0]          cfg_data;

  int cos_q15 [0:COS_DEPTH];

  logic [LEN_W-1:0]   win_len;
  logic [PHASE_W-1:0] step_phase;
  logic [ALPHA_W-1:0] win_alpha;
  logic [LEN_W-1:0]   sample_idx;
  logic [PHASE_W-1:0] acc_phase;

  windowed_t windowed_q[$];

  int n_sent;
  int n_checked;
  int n_windows;
  int n_writes;
  int n_errors;

  bit        tx_gaps;
  int        burst_left;
  rx_style_t rx_style;
  int        stall_left;

  blackman_window_apply uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample_in   (in_sample_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sample_out (out_sample_out),
    .out_window_end (out_window_end),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("tb_top failed");
    $finish;
  end

  function automatic void build_cos_table();
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          acc;
    for (int k = 0; k < COS_DEPTH; k++) begin
      x    = (64'd1686629713 * 64'(k)) / 64'(COS_DEPTH);
      x2   = (x * x) >> 30;
      term = 64'd1 << 30;
      acc  = longint'(term);
      for (int n = 1; n <= 7; n++) begin
        term = ((term * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
        if (n % 2 == 1) begin
          acc = acc - longint'(term);
        end else begin
          acc = acc + longint'(term);
        end
      end
      if (acc < 0) begin
        acc = 0;
      end
      acc = (acc + 16384) >>> 15;
      if (acc > 32768) begin
        acc = 32768;
      end
      cos_q15[k] = int'(acc);
    end
    cos_q15[COS_DEPTH] = 0;
  endfunction

  function automatic int cos_of_phase(input logic [PHASE_W-1:0] p);
    int unsigned j;
    j = int'((longint'(p[PHASE_W-3:0]) * COS_DEPTH) >> (PHASE_W - 2));
    case (p[PHASE_W-1:PHASE_W-2])
      2'd0:    return cos_q15[j];
      2'd1:    return -cos_q15[COS_DEPTH - j];
      2'd2:    return -cos_q15[j];
      default: return cos_q15[COS_DEPTH - j];
    endcase
  endfunction

  function automatic windowed_t window_sample(input logic signed [SAMPLE_W-1:0] s);
    windowed_t          r;
    int                 n;
    int                 a;
    int                 c1;
    int                 c2;
    logic [PHASE_W-1:0] p;
    longint             w;
    longint             y;
    n = int'(win_len);
    if (n < 2) begin
      n = 2;
    end
    if (n > MAX_LENGTH) begin
      n = MAX_LENGTH;
    end
    p  = acc_phase + step_phase;
    c1 = cos_of_phase(p);
    c2 = cos_of_phase({p[PHASE_W-2:0], 1'b0});
    a  = int'(win_alpha);
    w  = longint'(65536 - a) * 32768 - longint'(c1) * 65536 + longint'(a) * c2;
    y  = (longint'(s) * w + (longint'(1) <<< 31)) >>> 32;
    if (y > 32767) begin
      y = 32767;
    end
    if (y < -32768) begin
      y = -32768;
    end
    r.value = y[SAMPLE_W-1:0];
    if (int'(sample_idx) >= n - 1) begin
      r.last     = 1'b1;
      sample_idx = '0;
      acc_phase  = '0;
    end else begin
      r.last     = 1'b0;
      sample_idx = sample_idx + 1'b1;
      acc_phase  = p;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    windowed_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        windowed_q.push_back(window_sample(in_sample_in));
      end
      if (out_valid && out_ready) begin
        if (windowed_q.size() == 0) begin
          $error("unexpected item: sample_out %0d window_end %0b",
                 out_sample_out, out_window_end);
          n_errors++;
        end else begin
          want = windowed_q.pop_front();
          n_checked++;
          if (out_sample_out !== want.value) begin
            $error("sample_out: expected %0d, got %0d", want.value, out_sample_out);
            n_errors++;
          end
          if (out_window_end !== want.last) begin
            $error("window_end: expected %0b, got %0b", want.last, out_window_end);
            n_errors++;
          end
          if (want.last) begin
            n_windows++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_WINDOW_LENGTH: win_len    = cfg_data[LEN_W-1:0];
          CFG_PHASE_STEP:    step_phase = cfg_data[PHASE_W-1:0];
          CFG_ALPHA:         win_alpha  = cfg_data[ALPHA_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      case (rx_style)
        RX_FREE:   out_ready <= 1'b1;
        RX_CHOPPY: out_ready <= ($urandom_range(0, 3) != 0);
        default: begin
          if ($urandom_range(0, 15) == 0) begin
            stall_left = $urandom_range(2, 20);
            out_ready <= 1'b0;
          end else begin
            out_ready <= 1'b1;
          end
        end
      endcase
    end
  end

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
    int gap;
    if (burst_left == 0) begin
      gap        = tx_gaps ? $urandom_range(0, 6) : 0;
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid     <= 1'b1;
    in_sample_in <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (windowed_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IW-1:0] idx,
                                input logic [CFG_DW-1:0] data);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    n_writes++;
  endtask

  task automatic set_window(input int unsigned len, input int unsigned step,
                            input int unsigned a);
    logic [CFG_DW-1:0] data;
    data = $urandom;
    data[LEN_W-1:0] = len[LEN_W-1:0];
    write_register(CFG_WINDOW_LENGTH, data);
    write_register(CFG_PHASE_STEP, step[PHASE_W-1:0]);
    data = $urandom;
    data[ALPHA_W-1:0] = a[ALPHA_W-1:0];
    write_register(CFG_ALPHA, data);
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 11))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic test_reset_settings();
    send_sample(-16'sd32768);
    send_sample(16'sd32767);
    send_sample(16'sd0);
    send_sample(-16'sd1);
    send_sample(16'h5555);
    send_sample(16'hAAAA);
  endtask

  task automatic test_phase_quadrants();
    set_window(4, 24'h400000, ALPHA_RESET);
    repeat (5) send_sample(pick_sample());
    set_window(2, 24'h800000, ALPHA_RESET);
    send_sample(16'sd32767);
    send_sample(-16'sd32768);
    set_window(3, 24'hFFFFFF, ALPHA_RESET);
    repeat (3) send_sample(pick_sample());
  endtask

  task automatic test_short_lengths();
    set_window(0, 24'h555555, ALPHA_RESET);
    repeat (3) send_sample(pick_sample());
    set_window(1, 24'h2AAAAB, ALPHA_RESET);
    repeat (3) send_sample(pick_sample());
  endtask

  task automatic test_zero_step();
    set_window(5, 0, ALPHA_RESET);
    repeat (3) send_sample(16'sd32767);
  endtask

  task automatic test_alpha_extremes();
    set_window(8, 24'h200000, 0);
    repeat (3) send_sample(-16'sd32768);
    set_window(8, 24'h200000, 65535);
    repeat (3) send_sample(16'sd32767);
  endtask

  task automatic test_length_shrink();
    set_window(8, 24'h200000, ALPHA_RESET);
    repeat (5) send_sample(pick_sample());
    set_window(3, 24'h555555, ALPHA_RESET);
    repeat (2) send_sample(pick_sample());
  endtask

  task automatic test_spare_index();
    write_register(CFG_SPARE, CFG_DW'($urandom));
    repeat (2) send_sample(pick_sample());
  endtask

  task automatic test_random_windows();
    int          done;
    int          k;
    int unsigned len;
    int unsigned nn;
    int unsigned step;
    int unsigned a;
    int          count;
    done = 0;
    while (done < RANDOM_ITEMS) begin
      k   = $urandom_range(0, 9);
      len = $urandom_range(2, 64);
      if (k == 6) begin
        len = $urandom_range(65, MAX_LENGTH);
      end else if (k == 7) begin
        len = $urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom_range(MAX_LENGTH + 1, 8191);
      end
      nn = (len < 2) ? 2 : (len > MAX_LENGTH) ? MAX_LENGTH : len;
      step = ((32'd1 << PHASE_W) + nn / 2) / nn;
      if (k == 8) begin
        step = $urandom_range(0, 24'hFFFFFF);
      end
      a = $urandom_range(0, 65535);
      if (k == 9) begin
        a = $urandom_range(0, 1) ? 0 : 65535;
      end
      set_window(len, step, a);
      if ($urandom_range(0, 3) == 0) begin
        tx_gaps  = 1'b0;
        rx_style = RX_FREE;
      end else begin
        tx_gaps  = $urandom_range(0, 3) != 0;
        rx_style = rx_style_t'($urandom_range(0, 2));
      end
      count = nn * $urandom_range(1, 3) + $urandom_range(0, nn);
      if (count > 160) begin
        count = $urandom_range(40, 160);
      end
      repeat (count) send_sample(pick_sample());
      done += count;
    end
  endtask

  task automatic test_max_length_clamp();
    tx_gaps  = 1'b0;
    rx_style = RX_FREE;
    set_window(8191, 4096, ALPHA_RESET);
    repeat (64) send_sample(pick_sample());
  endtask

  initial begin
    build_cos_table();
    win_len      = WINDOW_LENGTH_RESET;
    step_phase   = PHASE_STEP_RESET;
    win_alpha    = ALPHA_RESET;
    sample_idx   = '0;
    acc_phase    = '0;
    tx_gaps      = 1'b1;
    burst_left   = 0;
    rx_style     = RX_BLOCKY;
    stall_left   = 0;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_sample_in <= '0;
    out_ready    <= 1'b0;
    cfg_valid    <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_settings();
    test_phase_quadrants();
    test_short_lengths();
    test_zero_step();
    test_alpha_extremes();
    test_length_shrink();
    test_spare_index();
    test_random_windows();
    test_max_length_clamp();
    wait_idle();
    repeat (10) @(posedge clk);

    $display("%0d items sent, %0d checked, %0d windows closed", n_sent, n_checked, n_windows);
    $display("%0d register writes across directed and random settings", n_writes);
    if (n_errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
